/* rtl/core/mcb_pkg.sv */
// Maze carver package: field widths, function/direction/cell codes,
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
package mcb_pkg;

  localparam int MAX_DIM_DEF     = 64;
  localparam int STACK_DEPTH_DEF = 1024;

  localparam int FUNC_W  = 2;
  localparam int DIR_W   = 2;
  localparam int COORD_W = 6;
  localparam int CNT_W   = 11;
  localparam int CODE_W  = 2;
  localparam int GRID_W  = 7;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;
  localparam int ADDR_LSB = 2;
  localparam int MIN_DIM = 5;

  localparam logic [GRID_W-1:0] GRID_RESET = 7'd31;

  localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  localparam logic [CODE_W-1:0] CODE_OPEN      = 2'd0;
  localparam logic [CODE_W-1:0] CODE_WALL      = 2'd1;
  localparam logic [CODE_W-1:0] CODE_UNVISITED = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // which cell a map row read targets
  typedef logic [2:0] row_src_t;
  localparam row_src_t SRC_UP   = 3'd0;
  localparam row_src_t SRC_MID  = 3'd1;
  localparam row_src_t SRC_DN   = 3'd2;
  localparam row_src_t SRC_SEL  = 3'd3;
  localparam row_src_t SRC_CMID = 3'd4;
  localparam row_src_t SRC_CTGT = 3'd5;

  typedef struct packed {
    logic     load_item;
    logic     clr_res;
    logic     init;
    logic     row_rd;
    row_src_t row_src;
    logic     row_wr;
    logic     cap_up;
    logic     cap_mid;
    logic     cap_dn;
    logic     cap_code;
    logic     set_done;
    logic     pop_issue;
    logic     pop_load;
    logic     scan_start;
    logic     scan_run;
    logic     push;
    logic     move;
    logic     set_rej;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              done;
    logic              cnt_zero;
    logic              cnt_multi;
    logic              dir_ok;
    logic              sp_zero;
    logic              stk_full;
    logic              scan_done;
    logic              seen;
  } dp_stat_t;

endpackage

/* rtl/core/maze_carver_backtracker.sv */
// Maze carver top level: config registers on the APB port, controller and datapath.
// out_valid rises from the finish state: init, no-op and finished step go there directly;
// read captures the cell code; a dead end sets done on an empty stack or pops; one unvisited
// neighbor is rejected or moved; with several, a duplicate scan of the stack entries runs
// first (stopping early on a match), one stack read per cycle.
// One item in flight; the next item is accepted the cycle out_valid rises unless the
// previous result still waits. Sync reset clears control state, walker and stack pointer;
// per-row valid bits make the open map read as all zero at once, no clearing pass.
module maze_carver_backtracker #(
  parameter int MAX_DIM     = mcb_pkg::MAX_DIM_DEF,
  parameter int STACK_DEPTH = mcb_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcb_pkg::FUNC_W-1:0]    in_func,
  input  logic [mcb_pkg::DIR_W-1:0]     in_rand_dir,
  input  logic [mcb_pkg::COORD_W-1:0]   in_sel_row,
  input  logic [mcb_pkg::COORD_W-1:0]   in_sel_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mcb_pkg::COORD_W-1:0]   out_cur_row,
  output logic [mcb_pkg::COORD_W-1:0]   out_cur_col,
  output logic                          out_moved,
  output logic                          out_rejected,
  output logic                          out_finished,
  output logic [mcb_pkg::CNT_W-1:0]     out_stack_count,
  output logic [mcb_pkg::CODE_W-1:0]    out_cell_code,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcb_pkg::PADDR_W-1:0]   paddr,
  input  logic [mcb_pkg::DATA_W-1:0]    pwdata,
  output logic [mcb_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import mcb_pkg::*;

  logic [GRID_W-1:0] grid_rows_r, grid_cols_r;
  logic              reg_idx;
  logic              reg_wr;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_LSB];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_COLS) ? DATA_W'(grid_cols_r) : DATA_W'(grid_rows_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_RESET;
      grid_cols_r <= GRID_RESET;
    end else if (reg_wr) begin
      if (reg_idx == REG_ROWS) grid_rows_r <= pwdata[GRID_W-1:0];
      else grid_cols_r <= pwdata[GRID_W-1:0];
    end
  end

  mcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mcb_dpath #(
    .MAX_DIM     (MAX_DIM),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .grid_rows       (grid_rows_r),
    .grid_cols       (grid_cols_r),
    .in_func         (in_func),
    .in_rand_dir     (in_rand_dir),
    .in_sel_row      (in_sel_row),
    .in_sel_col      (in_sel_col),
    .cmd             (cmd),
    .stat            (stat),
    .out_cur_row     (out_cur_row),
    .out_cur_col     (out_cur_col),
    .out_moved       (out_moved),
    .out_rejected    (out_rejected),
    .out_finished    (out_finished),
    .out_stack_count (out_stack_count),
    .out_cell_code   (out_cell_code)
  );

endmodule

/* rtl/core/mcb_dpath.sv */
// Maze carver datapath: item and walker registers, open map (row memory with
// per-row valid bits), backtrack stack memory with duplicate scan, result registers.
// Depends on mcb_pkg.
module mcb_dpath #(
  parameter int MAX_DIM     = mcb_pkg::MAX_DIM_DEF,
  parameter int STACK_DEPTH = mcb_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mcb_pkg::GRID_W-1:0]   grid_rows,
  input  logic [mcb_pkg::GRID_W-1:0]   grid_cols,
  input  logic [mcb_pkg::FUNC_W-1:0]   in_func,
  input  logic [mcb_pkg::DIR_W-1:0]    in_rand_dir,
  input  logic [mcb_pkg::COORD_W-1:0]  in_sel_row,
  input  logic [mcb_pkg::COORD_W-1:0]  in_sel_col,
  input  mcb_pkg::dp_cmd_t             cmd,
  output mcb_pkg::dp_stat_t            stat,
  output logic [mcb_pkg::COORD_W-1:0]  out_cur_row,
  output logic [mcb_pkg::COORD_W-1:0]  out_cur_col,
  output logic                         out_moved,
  output logic                         out_rejected,
  output logic                         out_finished,
  output logic [mcb_pkg::CNT_W-1:0]    out_stack_count,
  output logic [mcb_pkg::CODE_W-1:0]   out_cell_code
);
  import mcb_pkg::*;

  localparam int CW  = $clog2(MAX_DIM);
  localparam int EW  = CW + 1;
  localparam int XW  = (CW + 2 > GRID_W) ? CW + 2 : GRID_W;
  localparam int VW  = (EW > GRID_W) ? EW : GRID_W;
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SEW = 2 * CW;

  function automatic logic [EW-1:0] eff_dim(input logic [GRID_W-1:0] v);
    logic [VW-1:0] vx;
    logic [VW-1:0] res;
    vx = VW'(v);
    if (vx < VW'(MIN_DIM)) res = VW'(MIN_DIM);
    else if (vx > VW'(MAX_DIM)) res = VW'(MAX_DIM);
    else res = vx;
    return EW'(res);
  endfunction

  function automatic logic [CW-1:0] clamp_start(input logic [XW-1:0] sel,
                                                input logic [EW-1:0] dim);
    logic [XW-1:0] top;
    logic [XW-1:0] v;
    top = XW'(dim) - XW'(2);
    if (!top[0]) top = top - XW'(1);
    v = sel | XW'(1);
    if (v > top) v = top;
    return v[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] map_idx(input logic [XW-1:0] v);
    return (v < XW'(MAX_DIM)) ? v[CW-1:0] : '0;
  endfunction

  function automatic logic row_bit(input logic [MAX_DIM-1:0] row,
                                   input logic [XW-1:0] c);
    return (c < XW'(MAX_DIM)) ? row[c[CW-1:0]] : 1'b0;
  endfunction

  function automatic logic [CODE_W-1:0] cell_code(input logic [XW-1:0] r,
                                                   input logic [XW-1:0] c,
                                                   input logic opn,
                                                   input logic [EW-1:0] rows,
                                                   input logic [EW-1:0] cols);
    logic [XW-1:0] rx;
    logic [XW-1:0] cx;
    logic [CODE_W-1:0] code;
    rx = XW'(rows);
    cx = XW'(cols);
    if (r[XW-1] || c[XW-1] || r >= rx || c >= cx) code = CODE_WALL;
    else if (opn) code = CODE_OPEN;
    else if (r <= rx - XW'(2) && c <= cx - XW'(2) && r[0] && c[0]) code = CODE_UNVISITED;
    else code = CODE_WALL;
    return code;
  endfunction

  // item registers
  logic [FUNC_W-1:0]  func_r;
  logic [DIR_W-1:0]   dir_r;
  logic [COORD_W-1:0] selr_r, selc_r;

  // walk state
  logic [CW-1:0]  walk_row_r, walk_col_r;
  logic [SPW-1:0] sp_r;
  logic           done_r;

  // open map
  logic [MAX_DIM-1:0] open_mem [MAX_DIM];
  logic [MAX_DIM-1:0] row_vld_r;
  logic [MAX_DIM-1:0] row_q_r;
  logic               row_q_vld_r;
  logic [MAX_DIM-1:0] row_q_eff;
  logic [XW-1:0]      rmw_row_r, rmw_col_r;
  logic [3:0]         nb_open_r;

  // backtrack stack
  logic [SEW-1:0] stk_mem [STACK_DEPTH];
  logic [SEW-1:0] stk_q_r;
  logic [SPW-1:0] scan_idx_r;
  logic           scan_pend_r, seen_r;
  logic           scan_rd, stk_rd;
  logic [SIW-1:0] stk_addr;
  logic [SPW-1:0] sp_m1;
  logic [SEW-1:0] cur_ent;

  // results
  logic              moved_r, rej_r;
  logic [CODE_W-1:0] code_r;

  logic [EW-1:0] rows_eff, cols_eff;
  logic [XW-1:0] wr_x, wc_x;
  logic [XW-1:0] src_row, src_col;
  logic [XW-1:0] cmid_row, cmid_col, ctgt_row, ctgt_col;
  logic [XW-1:0] nb_row [4];
  logic [XW-1:0] nb_col [4];
  logic [3:0]    nb_unv;
  logic [CW-1:0] init_row, init_col;

  assign rows_eff  = eff_dim(grid_rows);
  assign cols_eff  = eff_dim(grid_cols);
  assign wr_x      = XW'(walk_row_r);
  assign wc_x      = XW'(walk_col_r);
  assign row_q_eff = row_q_vld_r ? row_q_r : '0;
  assign init_row  = clamp_start(XW'(selr_r), rows_eff);
  assign init_col  = clamp_start(XW'(selc_r), cols_eff);
  assign cur_ent   = {walk_row_r, walk_col_r};
  assign sp_m1     = sp_r - SPW'(1);

  assign nb_row[0] = wr_x - XW'(2);
  assign nb_col[0] = wc_x;
  assign nb_row[1] = wr_x;
  assign nb_col[1] = wc_x - XW'(2);
  assign nb_row[2] = wr_x + XW'(2);
  assign nb_col[2] = wc_x;
  assign nb_row[3] = wr_x;
  assign nb_col[3] = wc_x + XW'(2);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nb_unv[k] = (cell_code(nb_row[k], nb_col[k], nb_open_r[k], rows_eff, cols_eff)
                   == CODE_UNVISITED);
    end
  end

  // wall cell and target cell for the drawn direction
  always_comb begin
    unique case (dir_r)
      DIR_UP: begin
        cmid_row = wr_x - XW'(1); cmid_col = wc_x;
        ctgt_row = wr_x - XW'(2); ctgt_col = wc_x;
      end
      DIR_LEFT: begin
        cmid_row = wr_x; cmid_col = wc_x - XW'(1);
        ctgt_row = wr_x; ctgt_col = wc_x - XW'(2);
      end
      DIR_DOWN: begin
        cmid_row = wr_x + XW'(1); cmid_col = wc_x;
        ctgt_row = wr_x + XW'(2); ctgt_col = wc_x;
      end
      default: begin
        cmid_row = wr_x; cmid_col = wc_x + XW'(1);
        ctgt_row = wr_x; ctgt_col = wc_x + XW'(2);
      end
    endcase
  end

  always_comb begin
    unique case (cmd.row_src)
      SRC_UP:   begin src_row = nb_row[0];     src_col = wc_x;          end
      SRC_DN:   begin src_row = nb_row[2];     src_col = wc_x;          end
      SRC_SEL:  begin src_row = XW'(selr_r);   src_col = XW'(selc_r);   end
      SRC_CMID: begin src_row = cmid_row;      src_col = cmid_col;      end
      SRC_CTGT: begin src_row = ctgt_row;      src_col = ctgt_col;      end
      default:  begin src_row = wr_x;          src_col = wc_x;          end
    endcase
  end

  assign scan_rd  = cmd.scan_run && (scan_idx_r < sp_r);
  assign stk_rd   = cmd.pop_issue || scan_rd;
  assign stk_addr = cmd.pop_issue ? sp_m1[SIW-1:0] : scan_idx_r[SIW-1:0];

  // memories and payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r <= in_func;
      dir_r  <= in_rand_dir;
      selr_r <= in_sel_row;
      selc_r <= in_sel_col;
    end
    if (cmd.row_rd) begin
      row_q_r     <= open_mem[map_idx(src_row)];
      row_q_vld_r <= row_vld_r[map_idx(src_row)];
      rmw_row_r   <= src_row;
      rmw_col_r   <= src_col;
    end
    if (cmd.init) begin
      open_mem[init_row] <= MAX_DIM'(1) << init_col;
    end else if (cmd.row_wr) begin
      open_mem[map_idx(rmw_row_r)] <= row_q_eff | (MAX_DIM'(1) << map_idx(rmw_col_r));
    end
    if (cmd.cap_up) nb_open_r[0] <= row_bit(row_q_eff, rmw_col_r);
    if (cmd.cap_mid) begin
      nb_open_r[1] <= row_bit(row_q_eff, rmw_col_r - XW'(2));
      nb_open_r[3] <= row_bit(row_q_eff, rmw_col_r + XW'(2));
    end
    if (cmd.cap_dn) nb_open_r[2] <= row_bit(row_q_eff, rmw_col_r);
    if (cmd.push) stk_mem[sp_r[SIW-1:0]] <= cur_ent;
    if (stk_rd) stk_q_r <= stk_mem[stk_addr];
    if (cmd.load_out) begin
      out_cur_row     <= COORD_W'(walk_row_r);
      out_cur_col     <= COORD_W'(walk_col_r);
      out_moved       <= moved_r;
      out_rejected    <= rej_r;
      out_finished    <= done_r;
      out_stack_count <= CNT_W'(sp_r);
      out_cell_code   <= code_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_row_r  <= '0;
      walk_col_r  <= '0;
      sp_r        <= '0;
      done_r      <= 1'b0;
      row_vld_r   <= '0;
      scan_idx_r  <= '0;
      scan_pend_r <= 1'b0;
      seen_r      <= 1'b0;
      moved_r     <= 1'b0;
      rej_r       <= 1'b0;
      code_r      <= CODE_OPEN;
    end else begin
      if (cmd.clr_res) begin
        moved_r <= 1'b0;
        rej_r   <= 1'b0;
        code_r  <= CODE_OPEN;
      end
      if (cmd.init) begin
        walk_row_r <= init_row;
        walk_col_r <= init_col;
        sp_r       <= '0;
        done_r     <= 1'b0;
        row_vld_r  <= MAX_DIM'(1) << init_row;
      end
      if (cmd.row_wr) row_vld_r[map_idx(rmw_row_r)] <= 1'b1;
      if (cmd.cap_code) begin
        code_r <= cell_code(rmw_row_r, rmw_col_r, row_bit(row_q_eff, rmw_col_r),
                            rows_eff, cols_eff);
      end
      if (cmd.set_done) done_r <= 1'b1;
      if (cmd.pop_issue) sp_r <= sp_m1;
      if (cmd.push) sp_r <= sp_r + SPW'(1);
      if (cmd.pop_load) begin
        walk_row_r <= stk_q_r[SEW-1:CW];
        walk_col_r <= stk_q_r[CW-1:0];
      end
      if (cmd.move) begin
        walk_row_r <= ctgt_row[CW-1:0];
        walk_col_r <= ctgt_col[CW-1:0];
        moved_r    <= 1'b1;
      end
      if (cmd.set_rej) rej_r <= 1'b1;
      if (cmd.scan_start) begin
        scan_idx_r  <= '0;
        scan_pend_r <= 1'b0;
        seen_r      <= 1'b0;
      end else if (cmd.scan_run) begin
        if (scan_rd) scan_idx_r <= scan_idx_r + SPW'(1);
        scan_pend_r <= scan_rd;
        if (scan_pend_r && stk_q_r == cur_ent) seen_r <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.func      = func_r;
    stat.done      = done_r;
    stat.cnt_zero  = (nb_unv == 4'd0);
    stat.cnt_multi = ((nb_unv & (nb_unv - 4'd1)) != 4'd0);
    stat.dir_ok    = nb_unv[dir_r];
    stat.sp_zero   = (sp_r == '0);
    stat.stk_full  = (sp_r == SPW'(STACK_DEPTH));
    stat.scan_done = seen_r || (!scan_pend_r && scan_idx_r == sp_r);
    stat.seen      = seen_r;
  end

endmodule

/* rtl/core/mcb_ctrl.sv */
// Maze carver controller: sequences init, read and step items over the
// datapath and owns the input/output handshakes. Depends on mcb_pkg.
module mcb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mcb_pkg::dp_stat_t stat,
  output mcb_pkg::dp_cmd_t  cmd
);
  import mcb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RDC   = 4'd2;
  localparam logic [3:0] S_NB1   = 4'd3;
  localparam logic [3:0] S_NB2   = 4'd4;
  localparam logic [3:0] S_NB3   = 4'd5;
  localparam logic [3:0] S_EVAL  = 4'd6;
  localparam logic [3:0] S_BKWR  = 4'd7;
  localparam logic [3:0] S_POP   = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_CARVE = 4'd10;
  localparam logic [3:0] S_CV1W  = 4'd11;
  localparam logic [3:0] S_CV2R  = 4'd12;
  localparam logic [3:0] S_CV2W  = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        cmd.clr_res = 1'b1;
        state_nxt   = S_FIN;
        unique case (stat.func)
          FUNC_INIT: cmd.init = 1'b1;
          FUNC_STEP: begin
            if (!stat.done) begin
              cmd.row_rd  = 1'b1;
              cmd.row_src = SRC_UP;
              state_nxt   = S_NB1;
            end
          end
          FUNC_READ: begin
            cmd.row_rd  = 1'b1;
            cmd.row_src = SRC_SEL;
            state_nxt   = S_RDC;
          end
          default: ;
        endcase
      end
      S_RDC: begin
        cmd.cap_code = 1'b1;
        state_nxt    = S_FIN;
      end
      S_NB1: begin
        cmd.cap_up  = 1'b1;
        cmd.row_rd  = 1'b1;
        cmd.row_src = SRC_MID;
        state_nxt   = S_NB2;
      end
      S_NB2: begin
        cmd.cap_mid = 1'b1;
        cmd.row_rd  = 1'b1;
        cmd.row_src = SRC_DN;
        state_nxt   = S_NB3;
      end
      S_NB3: begin
        cmd.cap_dn = 1'b1;
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        priority if (stat.cnt_zero) begin
          // dead end: mark current cell open, then backtrack (or set done on an empty stack)
          cmd.row_rd  = 1'b1;
          cmd.row_src = SRC_MID;
          state_nxt   = S_BKWR;
        end else if (stat.cnt_multi) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          state_nxt = S_CARVE;
        end
      end
      S_BKWR: begin
        cmd.row_wr = 1'b1;
        if (!stat.sp_zero) begin
          cmd.pop_issue = 1'b1;
          state_nxt     = S_POP;
        end else begin
          cmd.set_done = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_FIN;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.push  = !stat.seen && !stat.stk_full;
          state_nxt = S_CARVE;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_CARVE: begin
        if (stat.dir_ok) begin
          cmd.row_rd  = 1'b1;
          cmd.row_src = SRC_CMID;
          state_nxt   = S_CV1W;
        end else begin
          cmd.set_rej = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_CV1W: begin
        cmd.row_wr = 1'b1;
        state_nxt  = S_CV2R;
      end
      S_CV2R: begin
        cmd.row_rd  = 1'b1;
        cmd.row_src = SRC_CTGT;
        state_nxt   = S_CV2W;
      end
      S_CV2W: begin
        cmd.row_wr = 1'b1;
        cmd.move   = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish state");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !stat.stk_full)
    else $error("push into full stack");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.row_wr |-> $past(cmd.row_rd))
    else $error("map row write without preceding read");

  a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_issue |=> cmd.pop_load)
    else $error("stack pop not completed");

endmodule
